>>> src/tilt_complementary_filter_defines.svh
// Assertion helpers shared by the filter's modules.
// Both expect a clock named clk and an active-low reset named arst_n.
`ifndef TILT_COMPLEMENTARY_FILTER_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_DEFINES_SVH

// Same-cycle implication.
`define TCF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/tcf_pkg.sv
`default_nettype none

package tcf_pkg;

	// Defaults for the top-level parameters
	localparam int TCF_CORDIC_STEPS    = 16;
	localparam int TCF_ANGLE_FRAC_BITS = 8;

	// Fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int OUT_W    = 17;
	localparam int ALPHA_W  = 17;
	localparam int GAIN_W   = 20;
	localparam int CFG_IDX_W = 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN   = 1'b1;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd64225;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 20'd128070;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;

	// CORDIC datapath: x/y carry the samples shifted up by 16 plus gain growth,
	// z is the angle in 1/65536 degree.
	localparam int XW = 35;
	localparam int ZW = 26;
	localparam logic signed [ZW-1:0] HALF_TURN = 26'sd11796480;

	// Gyro path: |gyro| * gain * elapsed is at most 52 bits
	localparam int PU_W = 52;
	localparam logic [63:0] P_MAX    = 64'd32768 * 64'd1048575 * 64'd65535;
	localparam logic [63:0] US_PER_S = 64'd1000000;
	localparam logic [63:0] DIV_HALF = US_PER_S << 23;

	// Microprogram
	localparam int STEP_W = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_GAIN,
		OP_TIME,
		OP_DIVIDEND,
		OP_ITER,
		OP_SUM,
		OP_ALPHA,
		OP_BETA,
		OP_WRITE
	} dp_op_t;

	typedef enum logic [1:0] {
		WAIT_NONE,
		WAIT_INPUT,
		WAIT_OUTPUT
	} wait_t;

	typedef enum logic [1:0] {
		JMP_NEVER,
		JMP_ALWAYS,
		JMP_LOOP_MORE
	} jump_t;

	typedef struct packed {
		dp_op_t              op;
		wait_t               wait_on;
		jump_t               jc;
		logic [STEP_W-1:0]   target;
	} ucode_t;

	typedef struct packed {
		dp_op_t op;
		logic   take_in;
		logic   emit;
	} dp_ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic loop_last;
	} seq_status_t;

	localparam logic [STEP_W-1:0] STEP_WAIT     = 4'd0;
	localparam logic [STEP_W-1:0] STEP_GAIN     = 4'd1;
	localparam logic [STEP_W-1:0] STEP_TIME     = 4'd2;
	localparam logic [STEP_W-1:0] STEP_DIVIDEND = 4'd3;
	localparam logic [STEP_W-1:0] STEP_ITER     = 4'd4;
	localparam logic [STEP_W-1:0] STEP_SUM      = 4'd5;
	localparam logic [STEP_W-1:0] STEP_ALPHA    = 4'd6;
	localparam logic [STEP_W-1:0] STEP_BETA     = 4'd7;
	localparam logic [STEP_W-1:0] STEP_WRITE    = 4'd8;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			STEP_WAIT:     w = '{OP_LOAD,     WAIT_INPUT,  JMP_NEVER,     STEP_WAIT};
			STEP_GAIN:     w = '{OP_GAIN,     WAIT_NONE,   JMP_NEVER,     STEP_WAIT};
			STEP_TIME:     w = '{OP_TIME,     WAIT_NONE,   JMP_NEVER,     STEP_WAIT};
			STEP_DIVIDEND: w = '{OP_DIVIDEND, WAIT_NONE,   JMP_NEVER,     STEP_WAIT};
			STEP_ITER:     w = '{OP_ITER,     WAIT_NONE,   JMP_LOOP_MORE, STEP_ITER};
			STEP_SUM:      w = '{OP_SUM,      WAIT_NONE,   JMP_NEVER,     STEP_WAIT};
			STEP_ALPHA:    w = '{OP_ALPHA,    WAIT_NONE,   JMP_NEVER,     STEP_WAIT};
			STEP_BETA:     w = '{OP_BETA,     WAIT_NONE,   JMP_NEVER,     STEP_WAIT};
			STEP_WRITE:    w = '{OP_WRITE,    WAIT_OUTPUT, JMP_ALWAYS,    STEP_WAIT};
			default:       w = '{OP_NOP,      WAIT_NONE,   JMP_ALWAYS,    STEP_WAIT};
		endcase
		return w;
	endfunction

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0:  v = 26'sd2949120;
			5'd1:  v = 26'sd1740967;
			5'd2:  v = 26'sd919879;
			5'd3:  v = 26'sd466945;
			5'd4:  v = 26'sd234379;
			5'd5:  v = 26'sd117304;
			5'd6:  v = 26'sd58666;
			5'd7:  v = 26'sd29335;
			5'd8:  v = 26'sd14668;
			5'd9:  v = 26'sd7334;
			5'd10: v = 26'sd3667;
			5'd11: v = 26'sd1833;
			5'd12: v = 26'sd917;
			5'd13: v = 26'sd458;
			5'd14: v = 26'sd229;
			5'd15: v = 26'sd115;
			5'd16: v = 26'sd57;
			5'd17: v = 26'sd29;
			5'd18: v = 26'sd14;
			5'd19: v = 26'sd7;
			5'd20: v = 26'sd4;
			5'd21: v = 26'sd2;
			5'd22: v = 26'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> src/tcf_sequencer.sv
`default_nettype none

`include "tilt_complementary_filter_defines.svh"

module tcf_sequencer
	import tcf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire seq_status_t status,
	output dp_ctrl_t         ctrl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_next;
	ucode_t            uw;
	logic              hold;
	logic              jump;

	assign uw = ucode_rom(step_q);

	always_comb begin
		hold = ((uw.wait_on == WAIT_INPUT) && !status.in_valid) ||
		       ((uw.wait_on == WAIT_OUTPUT) && status.out_busy);
		case (uw.jc)
			JMP_ALWAYS:    jump = 1'b1;
			JMP_LOOP_MORE: jump = !status.loop_last;
			default:       jump = 1'b0;
		endcase
		if (hold) begin
			step_next = step_q;
		end else if (jump) begin
			step_next = uw.target;
		end else begin
			step_next = step_q + 1'b1;
		end
	end

	always_comb begin
		ctrl.op      = uw.op;
		ctrl.take_in = (uw.op == OP_LOAD) && status.in_valid;
		ctrl.emit    = (uw.op == OP_WRITE) && !status.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= step_next;
		end
	end

	`TCF_ASSERT_NEXT(a_take_starts_program, ctrl.take_in, step_q == STEP_GAIN, "no gain step after take")
	`TCF_ASSERT_NEXT(a_emit_returns, ctrl.emit, step_q == STEP_WAIT, "no return to wait after emit")
	`TCF_ASSERT_NEXT(a_write_holds, (step_q == STEP_WRITE) && status.out_busy, step_q == STEP_WRITE, "write step left while output busy")

endmodule

`default_nettype wire

>>> src/tcf_datapath.sv
`default_nettype none

`include "tilt_complementary_filter_defines.svh"

module tcf_datapath
	import tcf_pkg::*;
#(
	parameter int CORDIC_STEPS    = TCF_CORDIC_STEPS,
	parameter int ANGLE_FRAC_BITS = TCF_ANGLE_FRAC_BITS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire dp_ctrl_t                   ctrl,
	input  wire logic signed [SAMPLE_W-1:0] accel_y,
	input  wire logic signed [SAMPLE_W-1:0] accel_z,
	input  wire logic signed [SAMPLE_W-1:0] gyro_x,
	input  wire logic [SAMPLE_W-1:0]        elapsed_us,
	input  wire logic [ALPHA_W-1:0]         blend_alpha,
	input  wire logic [GAIN_W-1:0]          gyro_gain,
	output logic                            loop_last,
	output logic signed [OUT_W-1:0]         roll_angle,
	output logic signed [OUT_W-1:0]         accel_angle
);

	localparam int AW = ANGLE_FRAC_BITS + 9;
	localparam logic [63:0] T_MAX = ((P_MAX << ANGLE_FRAC_BITS) + DIV_HALF) >> 24;
	localparam int QW = $clog2(T_MAX / US_PER_S + 64'd1);
	// 1e6 = 2^6 * 15625: the 2^6 is a shift, 15625 a reciprocal multiply
	localparam int RW = $clog2(T_MAX + 64'd1);
	localparam int DIV_TZ = 6;
	localparam logic [63:0] DIV_ODD = US_PER_S >> DIV_TZ;
	localparam int NW = RW - DIV_TZ;
	localparam int KW = NW + 14;
	localparam int MRW = NW + 1;
	localparam logic [MRW-1:0] RECIP = MRW'(((64'd1 << KW) + DIV_ODD - 64'd1) / DIV_ODD);
	localparam int LOOP_N = CORDIC_STEPS;
	localparam int CW = $clog2(LOOP_N);
	localparam int SW = ((AW > QW + 1) ? AW : QW + 1) + 1;
	localparam int OPA_W = (SW > 37) ? SW : 37;
	localparam int OPB_W = ALPHA_W + 1;
	localparam int PRW = OPA_W + OPB_W;
	localparam int MW = PRW + 1;
	localparam int WW = PU_W + ANGLE_FRAC_BITS + 1;
	localparam int ANG_LIM = 180 << ANGLE_FRAC_BITS;
	localparam int Z_HALF = 1 << (15 - ANGLE_FRAC_BITS);

	localparam logic signed [ZW:0] LIM_Z = (ZW + 1)'(ANG_LIM);
	localparam logic signed [ZW:0] HALF_Z = (ZW + 1)'(Z_HALF);
	localparam logic signed [MW-1:0] LIM_M = MW'(ANG_LIM);
	localparam logic signed [MW-1:0] HALF_M = MW'(32768);

	// CORDIC state
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic                 ay_zero_q;
	// gyro path
	logic                 gneg_q;
	logic [SAMPLE_W-1:0]  mag_q;
	logic [SAMPLE_W-1:0]  elapsed_q;
	logic signed [PRW-1:0] p_q;
	logic [RW-1:0]        r_q;
	logic [QW-1:0]        q_q;
	logic [CW-1:0]        cnt_q;
	// blend
	logic signed [AW-1:0] ang_q;
	logic signed [SW-1:0] s_q;
	logic signed [MW-1:0] m_q;
	logic signed [AW-1:0] roll_q;

	logic signed [XW-1:0] ay_ext, az_ext, xs, ys;
	logic signed [ZW-1:0] atan_i;
	logic                 cordic_on;
	logic [NW+MRW-1:0]    qprod;
	logic [WW-1:0]        wide;
	logic signed [ZW:0]   zr, zsh;
	logic signed [AW-1:0] ang_sat;
	logic signed [MW-1:0] msh;
	logic signed [AW-1:0] roll_next;
	logic [ALPHA_W-1:0]   alpha_eff, beta;
	logic signed [SW-1:0] qs, s_next;
	logic signed [OPA_W-1:0] opa;
	logic signed [OPB_W-1:0] opb;
	logic signed [PRW-1:0]   prod;

	assign ay_ext = XW'(accel_y) <<< 16;
	assign az_ext = XW'(accel_z) <<< 16;

	// one CORDIC rotation per loop step while accel Y is nonzero
	always_comb begin
		xs        = x_q >>> cnt_q;
		ys        = y_q >>> cnt_q;
		atan_i    = atan_q16(5'(cnt_q));
		cordic_on = !ay_zero_q && ({1'b0, cnt_q} < (CW + 1)'(CORDIC_STEPS));
		// rounding of the 1e6 * 2^24 divisor: the 2^24 part is a shift
		wide      = (WW'(p_q[PU_W-1:0]) << ANGLE_FRAC_BITS) + WW'(DIV_HALF);
		// floor(n / 15625), exact for n below 2^NW
		qprod     = (NW + MRW)'(r_q[RW-1:DIV_TZ]) * (NW + MRW)'(RECIP);
	end

	always_comb begin
		zr  = (ZW + 1)'(z_q) + HALF_Z;
		zsh = zr >>> (16 - ANGLE_FRAC_BITS);
		if (zsh > LIM_Z) begin
			ang_sat = AW'(LIM_Z);
		end else if (zsh < -LIM_Z) begin
			ang_sat = AW'(-LIM_Z);
		end else begin
			ang_sat = AW'(zsh);
		end
		msh = m_q >>> 16;
		if (msh > LIM_M) begin
			roll_next = AW'(LIM_M);
		end else if (msh < -LIM_M) begin
			roll_next = AW'(-LIM_M);
		end else begin
			roll_next = AW'(msh);
		end
	end

	always_comb begin
		alpha_eff = (blend_alpha > ALPHA_ONE) ? ALPHA_ONE : blend_alpha;
		beta      = ALPHA_ONE - alpha_eff;
		qs        = signed'(SW'(q_q));
		s_next    = gneg_q ? SW'(roll_q) - qs : SW'(roll_q) + qs;
	end

	// shared multiplier
	always_comb begin
		case (ctrl.op)
			OP_GAIN: begin
				opa = signed'(OPA_W'(gyro_gain));
				opb = signed'(OPB_W'(mag_q));
			end
			OP_TIME: begin
				opa = signed'(p_q[OPA_W-1:0]);
				opb = signed'(OPB_W'(elapsed_q));
			end
			OP_ALPHA: begin
				opa = OPA_W'(s_q);
				opb = signed'(OPB_W'(alpha_eff));
			end
			OP_BETA: begin
				opa = OPA_W'(ang_q);
				opb = signed'(OPB_W'(beta));
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign prod = opa * opb;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (ctrl.take_in) begin
					if (accel_z[SAMPLE_W-1]) begin
						x_q <= -az_ext;
						y_q <= -ay_ext;
						z_q <= accel_y[SAMPLE_W-1] ? -HALF_TURN : HALF_TURN;
					end else begin
						x_q <= az_ext;
						y_q <= ay_ext;
						z_q <= '0;
					end
					ay_zero_q <= (accel_y == '0);
					gneg_q    <= gyro_x[SAMPLE_W-1];
					mag_q     <= gyro_x[SAMPLE_W-1] ? SAMPLE_W'(-gyro_x) : SAMPLE_W'(gyro_x);
					elapsed_q <= elapsed_us;
				end
			end
			OP_GAIN, OP_TIME: begin
				p_q <= prod;
			end
			OP_DIVIDEND: begin
				r_q   <= RW'(wide >> 24);
				cnt_q <= '0;
			end
			OP_ITER: begin
				cnt_q <= cnt_q + 1'b1;
				q_q   <= QW'(qprod >> KW);
				if (cordic_on) begin
					if (!y_q[XW-1]) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_i;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_i;
					end
				end
			end
			OP_SUM: begin
				ang_q <= ang_sat;
				s_q   <= s_next;
			end
			OP_ALPHA: begin
				m_q <= MW'(prod);
			end
			OP_BETA: begin
				m_q <= m_q + MW'(prod) + HALF_M;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q <= '0;
		end else if (ctrl.emit) begin
			roll_q <= roll_next;
		end
	end

	assign loop_last   = (cnt_q == CW'(LOOP_N - 1));
	assign roll_angle  = OUT_W'(roll_next);
	assign accel_angle = OUT_W'(ang_q);

	`TCF_ASSERT_NOW(a_loop_bound, ctrl.op == OP_ITER, cnt_q <= CW'(LOOP_N - 1), "loop counter past end")
	`TCF_ASSERT_NOW(a_div_bound, ctrl.op == OP_ITER, r_q <= RW'(T_MAX), "gyro dividend out of range")

endmodule

`default_nettype wire

>>> src/tilt_complementary_filter.sv
// Complementary-filter roll estimator.
// Input stream (s_*): one transaction per sensor sample carrying accel Y/Z,
// gyro X and the microseconds since the previous sample. Output stream (m_*):
// one transaction per sample with the new roll estimate and the accel-only
// tilt, both signed with ANGLE_FRAC_BITS fraction bits of a degree.
// Config port: cfg_we writes cfg_data into register cfg_index
// (0 = blend_alpha, 1 = gyro_gain) at the clock edge; write only when idle.
// Operation: a microcoded sequencer steps one shared multiplier, a CORDIC stage
// and a reciprocal multiply that divides the gyro step by one million. The
// loop runs L = CORDIC_STEPS steps.
// m_tvalid rises after the gain, time, dividend, loop, sum, alpha, beta and
// write steps; the next sample is taken only once back at the wait step.
// Reset: roll estimate cleared, registers to their defaults, output empty.
// Stall: the result waits in the output register; the next sample is still
// accepted and processed, and the sequencer holds at its final step until
// the output register frees up.
`default_nettype none

module tilt_complementary_filter
	import tcf_pkg::*;
#(
	parameter int CORDIC_STEPS    = TCF_CORDIC_STEPS,
	parameter int ANGLE_FRAC_BITS = TCF_ANGLE_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [63:0]          s_tdata,   // accel_y, accel_z, gyro_x, elapsed_us
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [39:0]               m_tdata,   // roll_angle, accel_angle, zero pad
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [GAIN_W-1:0]    cfg_data
);

	logic [ALPHA_W-1:0] blend_alpha_q;
	logic [GAIN_W-1:0]  gyro_gain_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   roll_q;
	logic [OUT_W-1:0]   accel_q;

	dp_ctrl_t    ctrl;
	seq_status_t status;
	logic        loop_last;
	logic signed [OUT_W-1:0] roll_angle;
	logic signed [OUT_W-1:0] accel_angle;

	assign status.in_valid  = s_tvalid;
	assign status.out_busy  = m_tvalid_q && !m_tready;
	assign status.loop_last = loop_last;
	assign s_tready = (ctrl.op == OP_LOAD);

	tcf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	tcf_datapath #(
		.CORDIC_STEPS    (CORDIC_STEPS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.accel_y     (s_tdata[15:0]),
		.accel_z     (s_tdata[31:16]),
		.gyro_x      (s_tdata[47:32]),
		.elapsed_us  (s_tdata[63:48]),
		.blend_alpha (blend_alpha_q),
		.gyro_gain   (gyro_gain_q),
		.loop_last   (loop_last),
		.roll_angle  (roll_angle),
		.accel_angle (accel_angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_alpha_q <= ALPHA_RESET;
			gyro_gain_q   <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLEND_ALPHA: blend_alpha_q <= cfg_data[ALPHA_W-1:0];
				REG_GYRO_GAIN:   gyro_gain_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			roll_q  <= roll_angle;
			accel_q <= accel_angle;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, accel_q, roll_q};

endmodule

`default_nettype wire

>>> verif/tb_tilt_complementary_filter.sv
`timescale 1ns / 100ps

module tb_tilt_complementary_filter;
	import tcf_pkg::*;

	localparam int     FRAC      = TCF_ANGLE_FRAC_BITS;
	localparam longint ANGLE_LIM = longint'(180) << TCF_ANGLE_FRAC_BITS;
	localparam longint HALF_Q16  = 64'sd11796480;

	typedef struct {
		logic [OUT_W-1:0] roll;
		logic [OUT_W-1:0] tilt;
	} roll_pair_t;

	// Tracks the roll estimate and registers, predicts each output transaction.
	class roll_scoreboard;
		bit [ALPHA_W-1:0] alpha;
		bit [GAIN_W-1:0]  gain;
		longint           roll;
		longint           atan_lut[24];
		roll_pair_t       due[$];
		int               errors;

		function new();
			alpha    = ALPHA_RESET;
			gain     = GAIN_RESET;
			roll     = 0;
			errors   = 0;
			// atan(2^-i) in 1/65536 degree
			atan_lut = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
				29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
				4, 2, 1, 0};
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("[%0t] mismatch: %s", $realtime, msg);
			end
		endfunction

		function longint clamp180(longint v);
			if (v > ANGLE_LIM) return ANGLE_LIM;
			if (v < -ANGLE_LIM) return -ANGLE_LIM;
			return v;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
			if (idx == REG_BLEND_ALPHA) begin
				alpha = value[ALPHA_W-1:0];
			end else if (idx == REG_GYRO_GAIN) begin
				gain = value;
			end
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void note_sample(logic [63:0] d);
			longint     ay, az, gx, x, y, z, xs, ys, tilt, inc, a, s, mix;
			bit [63:0]  el, mag, num, q, den;
			roll_pair_t e;
			ay = longint'($signed(d[15:0]));
			az = longint'($signed(d[31:16]));
			gx = longint'($signed(d[47:32]));
			el = 64'(d[63:48]);

			// vectoring CORDIC, left half plane folded onto the right
			x = az * 65536;
			y = ay * 65536;
			z = 0;
			if (az < 0) begin
				z = (ay >= 0) ? HALF_Q16 : -HALF_Q16;
				x = -x;
				y = -y;
			end
			if (ay != 0) begin
				for (int i = 0; i < TCF_CORDIC_STEPS && i < 24; i++) begin
					xs = x >>> i;
					ys = y >>> i;
					if (y >= 0) begin
						x = x + ys;
						y = y - xs;
						z = z + atan_lut[i];
					end else begin
						x = x - ys;
						y = y + xs;
						z = z - atan_lut[i];
					end
				end
			end
			tilt = clamp180((z + (longint'(1) << (15 - FRAC))) >>> (16 - FRAC));

			// gyro step: round half away from zero on the magnitude
			mag = (gx < 0) ? 64'(-gx) : 64'(gx);
			num = ((mag * 64'(gain)) * el) << FRAC;
			den = 64'd1000000 << 24;
			q   = (num + den / 2) / den;
			inc = (gx < 0) ? -longint'(q) : longint'(q);

			a    = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
			s    = roll + inc;
			mix  = a * s + (65536 - a) * tilt + 32768;
			roll = clamp180(mix >>> 16);

			e.roll = roll[OUT_W-1:0];
			e.tilt = tilt[OUT_W-1:0];
			due.push_back(e);
		endfunction

		function void check_result(logic [39:0] d);
			roll_pair_t e;
			if (due.size() == 0) begin
				flag($sformatf("output with no sample pending: roll %0d tilt %0d",
					$signed(d[16:0]), $signed(d[33:17])));
			end else begin
				e = due.pop_front();
				if (d[16:0] !== e.roll) begin
					flag($sformatf("roll_angle expected %0d got %0d",
						$signed(e.roll), $signed(d[16:0])));
				end
				if (d[33:17] !== e.tilt) begin
					flag($sformatf("accel_angle expected %0d got %0d",
						$signed(e.tilt), $signed(d[33:17])));
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [63:0]          s_tdata   = '0;  // accel_y, accel_z, gyro_x, elapsed_us
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [39:0]          m_tdata;         // roll_angle, accel_angle, zero pad
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]    cfg_data  = '0;

	roll_scoreboard sb = new();

	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	int hold_req  = 0;

	tilt_complementary_filter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_sample(s_tdata);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
		end
	end

	// Output side: random stalls, plus a long hold-off on request.
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = recv_idle ? $urandom_range(0, 7) : 0;
			if (hold_req != 0) begin
				stall    = hold_req;
				hold_req = 0;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_item(input logic [15:0] ay, input logic [15:0] az,
		input logic [15:0] gx, input logic [15:0] el);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {el, gx, az, ay};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic configure(input logic [GAIN_W-1:0] alpha, input logic [GAIN_W-1:0] gain);
		cfg_we    <= 1'b1;
		cfg_index <= REG_BLEND_ALPHA;
		cfg_data  <= alpha;
		@(posedge clk);
		sb.write_reg(REG_BLEND_ALPHA, alpha);
		cfg_index <= REG_GYRO_GAIN;
		cfg_data  <= gain;
		@(posedge clk);
		sb.write_reg(REG_GYRO_GAIN, gain);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [15:0] pick_sample();
		int k;
		k = $urandom_range(0, 5);
		case (k)
			0, 1: return 16'($urandom);
			2: return 16'(int'($urandom_range(0, 128)) - 64);
			3: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return 16'(int'($urandom_range(14000, 18000)) *
				($urandom_range(0, 1) ? 1 : -1));
		endcase
	endfunction

	function automatic logic [15:0] pick_elapsed();
		int k;
		k = $urandom_range(0, 5);
		case (k)
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
			default: return 16'($urandom_range(4500, 5500));
		endcase
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			send_item(pick_sample(), pick_sample(), pick_sample(), pick_elapsed());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: register defaults
		send_item(0, 0, 0, 5000);               // both samples zero
		send_item(0, 100, 0, 5000);             // zero Y, Z positive
		send_item(0, -100, 0, 5000);            // zero Y, Z negative
		send_item(100, -100, 100, 5000);        // left half plane, upper
		send_item(-100, -100, -100, 5000);      // left half plane, lower
		send_item(32767, 32767, 32767, 65535);
		send_item(-32768, -32768, -32768, 65535);
		send_item(32767, -32768, -32768, 0);
		send_item(-32768, 32767, 32767, 1);
		send_item(1, -32768, 0, 5000);          // near +180, may overshoot
		send_item(-1, -32768, 0, 5000);         // near -180
		send_item(1, 32767, 5, 5000);
		send_item(16384, 0, 131, 5000);
		send_item(-16384, 0, -131, 5000);
		send_item(0, -32768, 0, 5000);
		send_item(-1, -1, -1, 65535);
		send_item(12000, 12000, -250, 5000);
		send_item(0, 0, 32767, 65535);
		send_item(23170, -23170, 1310, 5000);
		send_item(-23170, 23170, -5895, 5000);
		drain_results();

		// gyro only, max gain, back to back on both sides
		configure(ALPHA_ONE, 20'hfffff);
		send_idle = 1'b0;
		recv_idle = 1'b0;
		send_item(16384, 16384, 32767, 65535);
		send_item(16384, 16384, -32768, 65535);
		run_random(150);
		drain_results();

		// accel only, no gyro
		configure(20'd0, 20'd0);
		send_idle = 1'b1;
		recv_idle = 1'b1;
		run_random(100);
		drain_results();

		// alpha above one clamps
		configure(20'h1ffff, 20'd1);
		run_random(100);
		drain_results();

		// long output hold-off while input keeps coming
		configure(20'd1, 20'($urandom_range(0, 1048575)));
		send_idle = 1'b0;
		hold_req  = 400;
		run_random(150);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 0) begin
				configure(20'($urandom_range(0, 131071)), 20'($urandom_range(0, 1048575)));
			end else begin
				configure(20'($urandom_range(58000, 65536)), 20'($urandom_range(78000, 178000)));
			end
			send_idle = $urandom_range(0, 1);
			recv_idle = $urandom_range(0, 1);
			run_random(175);
			drain_results();
		end

		repeat (50) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.flag($sformatf("%0d results never arrived", sb.pending()));
		end
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/tcf_pkg.sv
src/tcf_sequencer.sv
src/tcf_datapath.sv
src/tilt_complementary_filter.sv
verif/tb_tilt_complementary_filter.sv
